### design/sdsi_pkg.sv
// Package for the SD card SPI-mode start-up sequencer.
// Holds the phase encoding, command and status codes and the CRC7 helpers.
// No dependencies; imported by sd_spi_init_sequencer.
`default_nettype none

package sdsi_pkg;

    // Sequencer phases, one-hot.
    typedef enum logic [10:0] {
        PH_IDLE  = 11'b000_0000_0001,
        PH_CMD0  = 11'b000_0000_0010,
        PH_CMD8  = 11'b000_0000_0100,
        PH_V2_55 = 11'b000_0000_1000,
        PH_V2_41 = 11'b000_0001_0000,
        PH_CMD58 = 11'b000_0010_0000,
        PH_V1_55 = 11'b000_0100_0000,
        PH_V1_41 = 11'b000_1000_0000,
        PH_CMD1  = 11'b001_0000_0000,
        PH_CMD59 = 11'b010_0000_0000,
        PH_CMD16 = 11'b100_0000_0000
    } t_phase;

    // Input function codes.
    localparam logic FUNC_START    = 1'b0;
    localparam logic FUNC_RESPONSE = 1'b1;

    // Command indexes.
    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
    localparam logic [5:0] ACMD_SD_OP     = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;
    localparam logic [5:0] CMD_READ_OCR   = 6'd58;
    localparam logic [5:0] CMD_CRC_ON     = 6'd59;

    // Command arguments and response patterns.
    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;
    localparam logic [7:0]  ECHO_VHS    = 8'h01;
    localparam logic [7:0]  ECHO_CHECK  = 8'hAA;
    localparam int          R1_ILLEGAL_BIT = 2;
    localparam int          OCR_CCS_BIT    = 30;

    // Completion status.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Card kinds.
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_MMC     = 3'd1;
    localparam logic [2:0] KIND_SD_V1   = 3'd2;
    localparam logic [2:0] KIND_SD_V2   = 3'd3;
    localparam logic [2:0] KIND_SD_HC   = 3'd4;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  CFG_IDLE_LIMIT = 2'd0;
    localparam logic [1:0]  CFG_OP_LIMIT   = 2'd1;
    localparam logic [1:0]  CFG_BLOCK_LEN  = 2'd2;
    localparam logic [15:0] IDLE_LIMIT_RST = 16'd50;
    localparam logic [11:0] OP_LIMIT_RST   = 12'hFFF;
    localparam logic [12:0] BLOCK_LEN_RST  = 13'd512;

    localparam int CMD_BITS = 40;

    // CRC7 (x^7 + x^3 + 1) of a 40-bit frame holding only bit k, sent
    // most significant bit first. Only ever called with constant k.
    function automatic logic [6:0] crc7_col(input int k);
        logic [CMD_BITS-1:0] msg;
        logic [6:0]          crc;
        logic                fb;
        msg = '0;
        msg[k] = 1'b1;
        crc = '0;
        for (int b = CMD_BITS - 1; b >= 0; b--) begin
            fb  = crc[6] ^ msg[b];
            crc = {crc[5:0], 1'b0};
            if (fb) begin
                crc = crc ^ 7'h09;
            end
        end
        return crc;
    endfunction

    // CRC byte of a command: the CRC is linear, so it is the XOR of the
    // columns of the set frame bits, followed by the end bit.
    function automatic logic [7:0] crc7_byte(input logic [5:0] idx,
                                             input logic [31:0] arg);
        logic [CMD_BITS-1:0] msg;
        logic [6:0]          crc;
        msg = {2'b01, idx, arg};
        crc = '0;
        for (int k = 0; k < CMD_BITS; k++) begin
            if (msg[k]) begin
                crc = crc ^ crc7_col(k);
            end
        end
        return {crc, 1'b1};
    endfunction

endpackage

`default_nettype wire

### design/sd_spi_init_sequencer.sv
// SD/MMC SPI-mode start-up sequencer.
//
// Input stream: s_axis_tuser selects start (0) or card response (1);
// s_axis_tdata carries the R1 byte and the four trailing response bytes.
// Output stream: s_axis results on m_axis, one result item per input item,
// either the next command to send (m_axis_tuser high) or the done report.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data
// write the CMD0 try limit (0), the ACMD41/CMD1 try limit (1) and the
// CMD16 block length (2); o_cfg_ready is always high.
//
// Timing: an item taken is held in the input register, worked on by the
// phase logic and its result registered for m_axis. One item per cycle is
// sustained while results are taken; the cost is one input register and
// one result register with the phase logic and CRC7 XOR tree between them.
// When the receiver stalls, the result register holds and the input
// register fills; s_axis_tready then drops until the result is taken.
// Reset clears the phase to idle, the counters, the detected card kind and
// the fast clock flag, and restores the register defaults.
// Depends on sdsi_pkg.
`default_nettype none

module sd_spi_init_sequencer
    import sdsi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // r1_byte[7:0], trailing_word[39:8]
    input  wire logic        s_axis_tuser,  // func[0]
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cmd_index[5:0], cmd_argument[37:6], crc_byte[45:38], expect_trailing[46],
    // init_clocks[47], fast_clock[48], done_res[49], status[51:50],
    // card_kind[54:52], zero pad[55]
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tuser,  // cmd_valid[0]
    // Configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_idle_limit;
    logic [11:0] r_op_limit;
    logic [12:0] r_block_len;

    // Input register.
    logic        r_in_valid;
    logic        r_in_func;
    logic [7:0]  r_in_r1;
    logic [31:0] r_in_tw;

    // Sequencer state.
    t_phase      r_phase,  n_phase;
    logic [15:0] r_tries,  n_tries;
    logic [2:0]  r_kind,   n_kind;
    logic        r_fast,   n_fast;

    // Result register.
    logic        r_out_valid;
    logic        r_out_cmd;
    logic [55:0] r_out_data;

    // Result fields built by the phase logic.
    logic        w_cmd;
    logic [5:0]  w_idx;
    logic [31:0] w_arg;
    logic        w_trail;
    logic        w_clocks;
    logic [1:0]  w_status;
    logic [7:0]  w_crc;
    logic        w_advance;
    logic        w_idle_hit;
    logic        w_op_hit;

    assign o_cfg_ready   = 1'b1;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_cmd;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
            r_op_limit   <= OP_LIMIT_RST;
            r_block_len  <= BLOCK_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDLE_LIMIT: r_idle_limit <= i_cfg_data;
                CFG_OP_LIMIT:   r_op_limit   <= i_cfg_data[11:0];
                CFG_BLOCK_LEN:  r_block_len  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Input register: takes a new item whenever it is empty or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= s_axis_tuser;
            r_in_r1   <= s_axis_tdata[7:0];
            r_in_tw   <= s_axis_tdata[39:8];
        end
    end

    assign w_idle_hit = r_tries >= r_idle_limit;
    assign w_op_hit   = r_tries >= {4'd0, r_op_limit};

    // Phase logic: decides the next command or the done report.
    always_comb begin
        n_phase  = PH_IDLE;
        n_tries  = r_tries;
        n_kind   = r_kind;
        n_fast   = r_fast;
        w_cmd    = 1'b0;
        w_idx    = CMD_GO_IDLE;
        w_arg    = '0;
        w_trail  = 1'b0;
        w_clocks = 1'b0;
        w_status = ST_ERROR;
        if (r_in_func == FUNC_START) begin
            n_tries  = 16'd1;
            n_kind   = KIND_UNKNOWN;
            n_fast   = 1'b0;
            n_phase  = PH_CMD0;
            w_cmd    = 1'b1;
            w_clocks = 1'b1;
        end else begin
            case (r_phase)
                PH_CMD0: begin
                    if (r_in_r1 == R1_IDLE) begin
                        n_tries = '0;
                        n_phase = PH_CMD8;
                        w_cmd   = 1'b1;
                        w_idx   = CMD_IF_COND;
                        w_arg   = ARG_IF_COND;
                        w_trail = 1'b1;
                    end else if (w_idle_hit) begin
                        w_status = ST_TIMEOUT;
                    end else begin
                        n_tries = r_tries + 16'd1;
                        n_phase = PH_CMD0;
                        w_cmd   = 1'b1;
                    end
                end
                PH_CMD8: begin
                    if (r_in_r1 == R1_IDLE) begin
                        if (r_in_tw[15:8] == ECHO_VHS && r_in_tw[7:0] == ECHO_CHECK) begin
                            n_tries = 16'd1;
                            n_phase = PH_V2_55;
                            w_cmd   = 1'b1;
                            w_idx   = CMD_APP;
                        end
                    end else if (r_in_r1[R1_ILLEGAL_BIT]) begin
                        n_tries = 16'd1;
                        n_phase = PH_V1_55;
                        w_cmd   = 1'b1;
                        w_idx   = CMD_APP;
                    end
                end
                PH_V2_55: begin
                    if (r_in_r1 != R1_IDLE) begin
                        w_status = ST_TIMEOUT;
                    end else begin
                        n_phase = PH_V2_41;
                        w_cmd   = 1'b1;
                        w_idx   = ACMD_SD_OP;
                        w_arg   = ARG_HCS;
                    end
                end
                PH_V2_41: begin
                    if (r_in_r1 == R1_READY) begin
                        n_phase = PH_CMD58;
                        w_cmd   = 1'b1;
                        w_idx   = CMD_READ_OCR;
                        w_trail = 1'b1;
                    end else if (w_op_hit) begin
                        w_status = ST_TIMEOUT;
                    end else begin
                        n_tries = r_tries + 16'd1;
                        n_phase = PH_V2_55;
                        w_cmd   = 1'b1;
                        w_idx   = CMD_APP;
                    end
                end
                PH_CMD58: begin
                    if (r_in_r1 != R1_READY) begin
                        w_status = ST_TIMEOUT;
                    end else begin
                        n_kind   = r_in_tw[OCR_CCS_BIT] ? KIND_SD_HC : KIND_SD_V2;
                        n_fast   = 1'b1;
                        w_status = ST_OK;
                    end
                end
                PH_V1_55: begin
                    if (r_in_r1 != R1_IDLE) begin
                        w_status = ST_TIMEOUT;
                    end else begin
                        n_phase = PH_V1_41;
                        w_cmd   = 1'b1;
                        w_idx   = ACMD_SD_OP;
                    end
                end
                PH_V1_41: begin
                    w_cmd = 1'b1;
                    if (r_in_r1 == R1_READY) begin
                        n_kind  = KIND_SD_V1;
                        n_fast  = 1'b1;
                        n_phase = PH_CMD59;
                        w_idx   = CMD_CRC_ON;
                    end else if (w_op_hit) begin
                        // Not an SD card: fall back to the MMC start-up.
                        n_tries = 16'd1;
                        n_phase = PH_CMD1;
                        w_idx   = CMD_SEND_OP;
                    end else begin
                        n_tries = r_tries + 16'd1;
                        n_phase = PH_V1_55;
                        w_idx   = CMD_APP;
                    end
                end
                PH_CMD1: begin
                    if (r_in_r1 == R1_READY) begin
                        n_kind  = KIND_MMC;
                        n_fast  = 1'b1;
                        n_phase = PH_CMD59;
                        w_cmd   = 1'b1;
                        w_idx   = CMD_CRC_ON;
                    end else if (w_op_hit) begin
                        w_status = ST_TIMEOUT;
                    end else begin
                        n_tries = r_tries + 16'd1;
                        n_phase = PH_CMD1;
                        w_cmd   = 1'b1;
                        w_idx   = CMD_SEND_OP;
                    end
                end
                PH_CMD59: begin
                    if (r_in_r1 != R1_READY) begin
                        w_status = ST_TIMEOUT;
                    end else begin
                        n_phase = PH_CMD16;
                        w_cmd   = 1'b1;
                        w_idx   = CMD_SET_BLKLEN;
                        w_arg   = {19'd0, r_block_len};
                    end
                end
                PH_CMD16: begin
                    w_status = (r_in_r1 != R1_READY) ? ST_TIMEOUT : ST_OK;
                end
                default: begin
                    // Response with nothing outstanding.
                    w_status = ST_ERROR;
                end
            endcase
        end
    end

    assign w_crc = crc7_byte(w_idx, w_arg);

    // Sequencer state advances once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tries <= '0;
            r_kind  <= KIND_UNKNOWN;
            r_fast  <= 1'b0;
        end else if (w_advance) begin
            r_phase <= n_phase;
            r_tries <= n_tries;
            r_kind  <= n_kind;
            r_fast  <= n_fast;
        end
    end

    // Result register: command fields zero on done, done fields zero on command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_cmd <= w_cmd;
            if (w_cmd) begin
                r_out_data <= {1'b0, KIND_UNKNOWN, ST_OK, 1'b0, n_fast,
                               w_clocks, w_trail, w_crc, w_arg, w_idx};
            end else begin
                r_out_data <= {1'b0, n_kind, w_status, 1'b1, n_fast,
                               1'b0, 1'b0, 8'd0, 32'd0, 6'd0};
            end
        end
    end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the SD/MMC SPI-mode start-up sequencer.
// Card responses are driven as items and each reply is checked against a predictor.
// Depends on sdsi_pkg and sd_spi_init_sequencer.
`timescale 1ns / 100ps

module tb;
    import sdsi_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [7:0] R1_NONE     = 8'hFF;

    // One reply of the sequencer, field by field.
    typedef struct packed {
        logic        cmd_valid;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic [7:0]  crc_byte;
        logic        expect_trailing;
        logic        init_clocks;
        logic        fast_clock;
        logic        done_res;
        logic [1:0]  status;
        logic [2:0]  card_kind;
    } t_reply;

    // Scoreboard: follows the start-up sequence and holds the replies still owed.
    class init_reply_board;
        t_reply      pending_q[$];
        t_phase      phase;
        logic [15:0] try_cnt;
        logic [2:0]  kind;
        logic        fast;
        logic [15:0] idle_lim;
        logic [11:0] op_lim;
        logic [12:0] blk_len;
        int          errors;

        function new();
            phase    = PH_IDLE;
            try_cnt  = '0;
            kind     = KIND_UNKNOWN;
            fast     = 1'b0;
            idle_lim = IDLE_LIMIT_RST;
            op_lim   = OP_LIMIT_RST;
            blk_len  = BLOCK_LEN_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_IDLE_LIMIT: idle_lim = val;
                CFG_OP_LIMIT:   op_lim   = val[11:0];
                CFG_BLOCK_LEN:  blk_len  = val[12:0];
                default: ;
            endcase
        endfunction

        // CRC7 of the start byte and argument, sent most significant bit first.
        function logic [7:0] crc7_of(logic [5:0] idx, logic [31:0] arg);
            logic [39:0] frame;
            logic [6:0]  r;
            logic        fb;
            frame = {2'b01, idx, arg};
            r     = '0;
            for (int n = 39; n >= 0; n--) begin
                fb = r[6] ^ frame[n];
                r  = {r[5:0], 1'b0};
                if (fb) begin
                    r = r ^ 7'h09;
                end
            end
            return {r, 1'b1};
        endfunction

        function t_reply issue_cmd(t_phase nxt, logic [5:0] idx, logic [31:0] arg,
                                   logic trail, logic clocks);
            t_reply rp;
            phase              = nxt;
            rp                 = '0;
            rp.cmd_valid       = 1'b1;
            rp.cmd_index       = idx;
            rp.cmd_argument    = arg;
            rp.crc_byte        = crc7_of(idx, arg);
            rp.expect_trailing = trail;
            rp.init_clocks     = clocks;
            rp.fast_clock      = fast;
            return rp;
        endfunction

        function t_reply report_done(logic [1:0] st);
            t_reply rp;
            phase         = PH_IDLE;
            rp            = '0;
            rp.fast_clock = fast;
            rp.done_res   = 1'b1;
            rp.status     = st;
            rp.card_kind  = kind;
            return rp;
        endfunction

        // Next reply of the sequencer for one card item; updates the state.
        function t_reply next_reply(logic func, logic [7:0] r1, logic [31:0] tw);
            t_reply rp;
            if (func == FUNC_START) begin
                try_cnt = 16'd1;
                kind    = KIND_UNKNOWN;
                fast    = 1'b0;
                return issue_cmd(PH_CMD0, CMD_GO_IDLE, '0, 1'b0, 1'b1);
            end
            case (phase)
                PH_CMD0: begin
                    // Success on the last try still wins over the timeout.
                    if (r1 == R1_IDLE) begin
                        try_cnt = '0;
                        rp = issue_cmd(PH_CMD8, CMD_IF_COND, ARG_IF_COND, 1'b1, 1'b0);
                    end else if (try_cnt >= idle_lim) begin
                        rp = report_done(ST_TIMEOUT);
                    end else begin
                        try_cnt = try_cnt + 16'd1;
                        rp = issue_cmd(PH_CMD0, CMD_GO_IDLE, '0, 1'b0, 1'b0);
                    end
                end
                PH_CMD8: begin
                    // No response at all counts as an illegal command: v1 path.
                    if (r1 == R1_IDLE) begin
                        if (tw[15:8] == ECHO_VHS && tw[7:0] == ECHO_CHECK) begin
                            try_cnt = 16'd1;
                            rp = issue_cmd(PH_V2_55, CMD_APP, '0, 1'b0, 1'b0);
                        end else begin
                            rp = report_done(ST_ERROR);
                        end
                    end else if (r1[R1_ILLEGAL_BIT]) begin
                        try_cnt = 16'd1;
                        rp = issue_cmd(PH_V1_55, CMD_APP, '0, 1'b0, 1'b0);
                    end else begin
                        rp = report_done(ST_ERROR);
                    end
                end
                PH_V2_55: begin
                    if (r1 != R1_IDLE) rp = report_done(ST_TIMEOUT);
                    else rp = issue_cmd(PH_V2_41, ACMD_SD_OP, ARG_HCS, 1'b0, 1'b0);
                end
                PH_V2_41: begin
                    if (r1 == R1_READY) begin
                        rp = issue_cmd(PH_CMD58, CMD_READ_OCR, '0, 1'b1, 1'b0);
                    end else if (try_cnt >= {4'd0, op_lim}) begin
                        rp = report_done(ST_TIMEOUT);
                    end else begin
                        try_cnt = try_cnt + 16'd1;
                        rp = issue_cmd(PH_V2_55, CMD_APP, '0, 1'b0, 1'b0);
                    end
                end
                PH_CMD58: begin
                    if (r1 != R1_READY) begin
                        rp = report_done(ST_TIMEOUT);
                    end else begin
                        kind = tw[OCR_CCS_BIT] ? KIND_SD_HC : KIND_SD_V2;
                        fast = 1'b1;
                        rp = report_done(ST_OK);
                    end
                end
                PH_V1_55: begin
                    if (r1 != R1_IDLE) rp = report_done(ST_TIMEOUT);
                    else rp = issue_cmd(PH_V1_41, ACMD_SD_OP, '0, 1'b0, 1'b0);
                end
                PH_V1_41: begin
                    // Out of SD attempts: fall back to CMD1 for MMC.
                    if (r1 == R1_READY) begin
                        kind = KIND_SD_V1;
                        fast = 1'b1;
                        rp = issue_cmd(PH_CMD59, CMD_CRC_ON, '0, 1'b0, 1'b0);
                    end else if (try_cnt >= {4'd0, op_lim}) begin
                        try_cnt = 16'd1;
                        rp = issue_cmd(PH_CMD1, CMD_SEND_OP, '0, 1'b0, 1'b0);
                    end else begin
                        try_cnt = try_cnt + 16'd1;
                        rp = issue_cmd(PH_V1_55, CMD_APP, '0, 1'b0, 1'b0);
                    end
                end
                PH_CMD1: begin
                    if (r1 == R1_READY) begin
                        kind = KIND_MMC;
                        fast = 1'b1;
                        rp = issue_cmd(PH_CMD59, CMD_CRC_ON, '0, 1'b0, 1'b0);
                    end else if (try_cnt >= {4'd0, op_lim}) begin
                        rp = report_done(ST_TIMEOUT);
                    end else begin
                        try_cnt = try_cnt + 16'd1;
                        rp = issue_cmd(PH_CMD1, CMD_SEND_OP, '0, 1'b0, 1'b0);
                    end
                end
                PH_CMD59: begin
                    if (r1 != R1_READY) rp = report_done(ST_TIMEOUT);
                    else rp = issue_cmd(PH_CMD16, CMD_SET_BLKLEN, {19'd0, blk_len}, 1'b0, 1'b0);
                end
                PH_CMD16: begin
                    if (r1 != R1_READY) rp = report_done(ST_TIMEOUT);
                    else rp = report_done(ST_OK);
                end
                // A response while idle is an error and leaves the phase idle.
                default: rp = report_done(ST_ERROR);
            endcase
            return rp;
        endfunction

        function void log_item(logic func, logic [7:0] r1, logic [31:0] tw);
            pending_q.push_back(next_reply(func, r1, tw));
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic cmd_valid, logic [55:0] d);
            t_reply want;
            if (pending_q.size() == 0) begin
                $error("Reply item arrived with none expected");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            cmp_field("cmd_valid", 32'(want.cmd_valid), 32'(cmd_valid));
            cmp_field("cmd_index", 32'(want.cmd_index), 32'(d[5:0]));
            cmp_field("cmd_argument", want.cmd_argument, d[37:6]);
            cmp_field("crc_byte", 32'(want.crc_byte), 32'(d[45:38]));
            cmp_field("expect_trailing", 32'(want.expect_trailing), 32'(d[46]));
            cmp_field("init_clocks", 32'(want.init_clocks), 32'(d[47]));
            cmp_field("fast_clock", 32'(want.fast_clock), 32'(d[48]));
            cmp_field("done_res", 32'(want.done_res), 32'(d[49]));
            cmp_field("status", 32'(want.status), 32'(d[51:50]));
            cmp_field("card_kind", 32'(want.card_kind), 32'(d[54:52]));
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;

    init_reply_board sb;
    int              gap_pct   = 0;
    int              stall_pct = 0;
    int              cycle_cnt = 0;

    sd_spi_init_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver side: random stalls, and every reply item taken is checked.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_reply(m_axis_tuser, m_axis_tdata);
        end
    end

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(input logic func, input logic [7:0] r1, input logic [31:0] tw);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {tw, r1};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.log_item(func, r1, tw);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and wait until every reply owed has been taken.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly a plausible card answer for the command just issued, some noise.
    task automatic send_card_item();
        int          roll;
        logic        func;
        logic [7:0]  r1;
        logic [31:0] tw;
        roll = $urandom_range(99);
        func = FUNC_RESPONSE;
        r1   = 8'($urandom_range(255));
        tw   = $urandom;
        if (roll < 6) begin
            func = 1'($urandom_range(1));
        end else begin
            roll = $urandom_range(99);
            case (sb.phase)
                PH_IDLE: if (roll < 85) func = FUNC_START;
                PH_CMD0: begin
                    if (roll < 55) r1 = R1_IDLE;
                    else if (roll < 80) r1 = R1_NONE;
                end
                PH_CMD8: begin
                    if (roll < 45) begin
                        r1 = R1_IDLE;
                        tw[15:0] = {ECHO_VHS, ECHO_CHECK};
                    end else if (roll < 55) begin
                        r1 = R1_IDLE;
                    end else if (roll < 70) begin
                        r1 = R1_NONE;
                    end else if (roll < 88) begin
                        r1[R1_ILLEGAL_BIT] = 1'b1;
                    end
                end
                PH_V2_55, PH_V1_55: if (roll < 88) r1 = R1_IDLE;
                PH_V2_41, PH_V1_41, PH_CMD1: begin
                    if (roll < 40) r1 = R1_READY;
                    else if (roll < 85) r1 = R1_IDLE;
                end
                // OCR read, CRC enable and block length all want a ready card.
                default: if (roll < 88) r1 = R1_READY;
            endcase
        end
        send_item(func, r1, tw);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: response while idle, then a v2 high-capacity card with one
        // CMD0 retry and one ACMD41 retry, then a v1 card that ignores CMD8.
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        send_item(FUNC_START, R1_NONE, 32'hFFFF_FFFF);
        send_item(FUNC_RESPONSE, R1_NONE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, {16'hFFFF, ECHO_VHS, ECHO_CHECK});
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'hC0FF_8000);
        send_item(FUNC_RESPONSE, 8'hFE, 32'h5555_AAAA);
        send_item(FUNC_START, R1_READY, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_NONE, 32'hFFFF_FFFF);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        settle();

        // Zero limits behave as one; block length 4096. CMD0 times out at
        // once, then succeeds on its only try and the card ends up as MMC.
        write_reg(CFG_IDLE_LIMIT, 16'd0);
        write_reg(CFG_OP_LIMIT, 16'd0);
        write_reg(CFG_BLOCK_LEN, 16'd4096);
        send_item(FUNC_START, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_NONE, 32'h0000_0000);
        send_item(FUNC_START, R1_NONE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_NONE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_IDLE, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        send_item(FUNC_RESPONSE, R1_READY, 32'h0000_0000);
        settle();

        // Random sequences over four idling patterns and register settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    gap_pct = 0;  stall_pct = 0;
                    write_reg(CFG_IDLE_LIMIT, 16'd3);
                    write_reg(CFG_OP_LIMIT, 16'd2);
                    write_reg(CFG_BLOCK_LEN, 16'd1);
                end
                1: begin
                    gap_pct = 74; stall_pct = 0;
                    write_reg(CFG_IDLE_LIMIT, 16'hFFFF);
                    write_reg(CFG_OP_LIMIT, 16'd4095);
                    write_reg(CFG_BLOCK_LEN, 16'd4096);
                end
                2: begin
                    gap_pct = 0;  stall_pct = 74;
                    write_reg(CFG_IDLE_LIMIT, 16'd1);
                    write_reg(CFG_OP_LIMIT, 16'd1);
                    write_reg(CFG_BLOCK_LEN, 16'($urandom_range(4096, 1)));
                end
                default: begin
                    gap_pct = 7;  stall_pct = 7;
                    write_reg(CFG_IDLE_LIMIT, 16'($urandom_range(4, 1)));
                    write_reg(CFG_OP_LIMIT, 16'($urandom_range(4, 1)));
                    write_reg(CFG_BLOCK_LEN, 16'($urandom_range(4096, 1)));
                end
            endcase
            repeat (200) send_card_item();
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
